// ===== hdl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants for the standard deviation unit
// Field widths, datapath widths and step counts of the shared-unit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

    // stream field widths
    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 8;
    localparam int STD_BITS      = 20;
    localparam int CNT_BITS      = 17;
    localparam int MAX_SAMPLES   = 65536;

    // accumulator widths
    localparam int SUM_BITS   = 29;
    localparam int SQSUM_BITS = 39;
    localparam int ABS_BITS   = SUM_BITS - 1;

    // shared adder/subtractor width, holds n*S2 and S1^2
    localparam int ALU_W = 56;

    // restoring square root and division
    localparam int ROOT_BITS  = ALU_W / 2 + FRACTION_BITS;
    localparam int SQRT_STEPS = ROOT_BITS;
    localparam int DIV_STEPS  = ROOT_BITS;
    localparam int STEP_BITS  = 6;

    // packed stream widths
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_FIELD_W = STD_BITS + CNT_BITS + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_SAMPLES);

    // snapshot of the accumulators handed to the sequencer
    typedef struct packed {
        logic [CNT_BITS-1:0]          count;
        logic signed [SUM_BITS-1:0]   sum;
        logic [SQSUM_BITS-1:0]        sqsum;
        logic                         dropped;
    } psd_stats_t;

    // one finished result
    typedef struct packed {
        logic                         overflow;
        logic [CNT_BITS-1:0]          count;
        logic [STD_BITS-1:0]          std_dev;
    } psd_result_t;

endpackage

`default_nettype wire

// ===== hdl/population_std_deviation_unit.sv =====
// Sequence: a sample transaction is absorbed into the registered accumulators; the terminator
//   starts 17 + 28 multiply steps, 36 root steps and 36 divide steps, then the output register.
// Throughput: one sample per cycle; the shared adder of the sequencer is busy
//   for the whole result computation and no sample is accepted meanwhile.
// An empty list goes from the terminator straight to the done state and the output register.
// Reset: synchronous, active low; clears accumulators, sequencer and output valid.
// ----------------------------------------------------------------------------
// population_std_deviation_unit: streaming population standard deviation
// Accumulates signed samples and, on the terminator -1, returns the truncated
// standard deviation with eight fractional bits, the sample count and a flag.
// ----------------------------------------------------------------------------
`default_nettype none

module population_std_deviation_unit
    import psd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [11:0] sample
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata   // [19:0] std_dev_q8, [36:20] sample_count,
                                                // [37] overflow
);

    logic                          eng_idle;
    logic                          res_valid;
    logic                          res_ready;
    psd_result_t                   result;
    psd_stats_t                    stats;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          s_fire;
    logic                          terminate;
    logic                          out_valid_reg;
    psd_result_t                   out_reg;

    assign sample    = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign s_tready  = eng_idle;
    assign s_fire    = s_tvalid && s_tready;
    assign terminate = s_fire && (sample == '1);

    psd_accum u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample_valid (s_fire),
        .terminate    (terminate),
        .sample       (sample),
        .stats        (stats)
    );

    psd_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (terminate),
        .stats     (stats),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.overflow, out_reg.count, out_reg.std_dev});

endmodule

`default_nettype wire

// ===== hdl/psd_accum.sv =====
// ----------------------------------------------------------------------------
// psd_accum: sample accumulators
// Keeps count, sum and sum of squares, one sample per cycle; cleared on the
// terminator transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_accum
    import psd_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          sample_valid,
    input  wire logic                          terminate,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output psd_stats_t                         stats
);

    logic [CNT_BITS-1:0]        count_reg, count_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic [SQSUM_BITS-1:0]      sqsum_reg, sqsum_next;
    logic                       drop_reg, drop_next;
    logic signed [2*SAMPLE_BITS-1:0] square;

    assign square = sample * sample;

    // accumulate or clear
    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sqsum_next = sqsum_reg;
        drop_next  = drop_reg;
        if (terminate) begin
            count_next = '0;
            sum_next   = '0;
            sqsum_next = '0;
            drop_next  = 1'b0;
        end else if (sample_valid) begin
            if (count_reg == MAX_COUNT) begin
                drop_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_BITS'(1);
                sum_next   = sum_reg + SUM_BITS'(sample);
                sqsum_next = sqsum_reg + SQSUM_BITS'($unsigned(square));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sqsum_reg <= sqsum_next;
            drop_reg  <= drop_next;
        end
    end

    assign stats.count   = count_reg;
    assign stats.sum     = sum_reg;
    assign stats.sqsum   = sqsum_reg;
    assign stats.dropped = drop_reg;

endmodule

`default_nettype wire

// ===== hdl/psd_alu.sv =====
// ----------------------------------------------------------------------------
// psd_alu: shared adder/subtractor
// One wide add or subtract with carry out; carry set on subtract means a >= b.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_alu
    import psd_pkg::*;
(
    input  wire logic [ALU_W-1:0] op_a,
    input  wire logic [ALU_W-1:0] op_b,
    input  wire logic             sub,
    output logic [ALU_W-1:0]      result,
    output logic                  carry
);

    logic [ALU_W-1:0] b_in;

    // two's complement subtract by inverting b and carrying in
    assign b_in = sub ? ~op_b : op_b;
    assign {carry, result} = {1'b0, op_a} + {1'b0, b_in} + {{ALU_W{1'b0}}, sub};

endmodule

`default_nettype wire

// ===== hdl/psd_engine.sv =====
// ----------------------------------------------------------------------------
// psd_engine: result sequencer
// Drives the shared adder through n*S2 - S1^2 by shift-add, a restoring
// square root and a restoring division by n.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_engine
    import psd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire psd_stats_t  stats,
    output logic             idle,
    output logic             res_valid,
    input  wire logic        res_ready,
    output psd_result_t      result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [ALU_W-1:0]       acc_reg, acc_next;     // product, then radicand
    logic [ALU_W-1:0]       op_reg, op_next;       // shifted multiplicand
    logic [ABS_BITS-1:0]    mlt_reg, mlt_next;     // multiplier bits
    logic [ABS_BITS-1:0]    abs_reg, abs_next;
    logic [ALU_W-1:0]       rem_reg, rem_next;
    logic [ROOT_BITS-1:0]   root_reg, root_next;   // root, then quotient
    logic [CNT_BITS-1:0]    n_reg, n_next;
    logic                   ovf_reg, ovf_next;

    logic [ALU_W-1:0]       alu_a, alu_b, alu_y;
    logic                   alu_sub, alu_c;
    logic [ALU_W-1:0]       rem_sh;
    logic [SUM_BITS-1:0]    sum_abs;

    psd_alu u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .sub    (alu_sub),
        .result (alu_y),
        .carry  (alu_c)
    );

    assign sum_abs = stats.sum[SUM_BITS-1] ? SUM_BITS'(-stats.sum) : SUM_BITS'(stats.sum);

    // operand selection for the shared adder
    always_comb begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        rem_sh  = '0;
        case (state_reg)
            ST_MUL_A: begin
                alu_b = mlt_reg[0] ? op_reg : '0;
            end
            ST_MUL_B: begin
                alu_b   = mlt_reg[0] ? op_reg : '0;
                alu_sub = 1'b1;
            end
            ST_SQRT: begin
                rem_sh  = {rem_reg[ALU_W-3:0], acc_reg[ALU_W-1:ALU_W-2]};
                alu_a   = rem_sh;
                alu_b   = ALU_W'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            ST_DIV: begin
                rem_sh  = {rem_reg[ALU_W-2:0], root_reg[ROOT_BITS-1]};
                alu_a   = rem_sh;
                alu_b   = ALU_W'(n_reg);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a = acc_reg;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        op_next    = op_reg;
        mlt_next   = mlt_reg;
        abs_next   = abs_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    n_next    = stats.count;
                    ovf_next  = stats.dropped;
                    abs_next  = sum_abs[ABS_BITS-1:0];
                    op_next   = ALU_W'(stats.sqsum);
                    mlt_next  = ABS_BITS'(stats.count);
                    acc_next  = '0;
                    root_next = '0;
                    step_next = '0;
                    state_next = (stats.count == '0) ? ST_DONE : ST_MUL_A;
                end
            end
            // acc = n * S2
            ST_MUL_A: begin
                acc_next  = alu_y;
                op_next   = {op_reg[ALU_W-2:0], 1'b0};
                mlt_next  = mlt_reg >> 1;
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(CNT_BITS - 1)) begin
                    op_next    = ALU_W'(abs_reg);
                    mlt_next   = abs_reg;
                    step_next  = '0;
                    state_next = ST_MUL_B;
                end
            end
            // acc -= |S1| * |S1|
            ST_MUL_B: begin
                acc_next  = alu_y;
                op_next   = {op_reg[ALU_W-2:0], 1'b0};
                mlt_next  = mlt_reg >> 1;
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(ABS_BITS - 1)) begin
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            // one root bit per step, radicand shifted out two bits at a time
            ST_SQRT: begin
                acc_next  = {acc_reg[ALU_W-3:0], 2'b00};
                if (alu_c) begin
                    rem_next  = alu_y;
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(SQRT_STEPS - 1)) begin
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            // one quotient bit per step, shifted in as the root shifts out
            ST_DIV: begin
                if (alu_c) begin
                    rem_next  = alu_y;
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
        acc_reg  <= acc_next;
        op_reg   <= op_next;
        mlt_reg  <= mlt_next;
        abs_reg  <= abs_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        n_reg    <= n_next;
        ovf_reg  <= ovf_next;
    end

    assign idle             = (state_reg == ST_IDLE);
    assign res_valid        = (state_reg == ST_DONE);
    assign result.std_dev   = root_reg[STD_BITS-1:0];
    assign result.count     = n_reg;
    assign result.overflow  = ovf_reg;

endmodule

`default_nettype wire

// ===== hdl/psd_checker.sv =====
// ----------------------------------------------------------------------------
// psd_checker: port-level checks for the standard deviation unit
// Watches the stream ports of the top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_checker
    import psd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // terminator transaction starts the computation, input closes
    a_busy_after_term: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[SAMPLE_BITS-1:0] == '1) |=> !s_tready)
        else $error("input still open after terminator");

    // count never beyond the limit
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[STD_BITS+CNT_BITS-1:STD_BITS] <= MAX_COUNT)
        else $error("sample count beyond limit");

    // dropped samples only once the limit was reached
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[STD_BITS+CNT_BITS] |->
            m_tdata[STD_BITS+CNT_BITS-1:STD_BITS] == MAX_COUNT)
        else $error("overflow flagged below the count limit");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:M_FIELD_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind population_std_deviation_unit psd_checker u_psd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
